>>> src/drm_pkg.sv
// drm_pkg: shared types and codes for the dirty rectangle merger
// transaction payload structs, command codes, controller/datapath interface structs
// no dependencies
package drm_pkg;

    // command codes carried by an input transaction
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // field width of the result count, and the internal coordinate width
    localparam int COUNT_OUT_W = 5;
    localparam int COORD_W     = 18;

    typedef logic signed [COORD_W-1:0] drm_coord_t;

    // input transaction
    typedef struct packed {
        logic        [1:0]  command;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_width;
        logic signed [15:0] rect_height;
    } drm_cmd_item_t;

    // result transaction
    typedef struct packed {
        logic signed [15:0]            region_x;
        logic signed [15:0]            region_y;
        logic        [16:0]            region_width;
        logic        [16:0]            region_height;
        logic                          region_valid;
        logic                          repaint_whole;
        logic        [COUNT_OUT_W-1:0] region_count;
        logic                          last;
    } drm_res_item_t;

    // controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic clear_table;
        logic idx_clear;
        logic idx_inc;
        logic rd_scan;
        logic rd_tail;
        logic merge;
        logic move_wr;
        logic append;
        logic overflow;
        logic out_status;
        logic out_region;
    } drm_ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] cmd;
        logic       add_ok;
        logic       count_zero;
        logic       idx_at_end;
        logic       idx_last;
        logic       hit;
        logic       table_full;
        logic       out_free;
    } drm_sts_t;

endpackage

>>> src/drm_ctrl.sv
// drm_ctrl: sequencing state machine for the dirty rectangle merger
// drives datapath commands from datapath status
// depends on drm_pkg
module drm_ctrl
    import drm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  drm_sts_t sts,
    output drm_ctl_t ctl
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_ADDR,
        S_SCAN_CMP,
        S_MOVE,
        S_FINISH,
        S_STATUS,
        S_LIST_ADDR,
        S_LIST_LOAD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // only take a new transaction when no work is pending
    assign cmd_stall = (state_reg != S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (sts.cmd)
                    CMD_CLEAR:
                    begin
                        ctl.clear_table = 1'b1;
                        state_next      = S_STATUS;
                    end
                    CMD_ADD:
                    begin
                        if (sts.add_ok)
                        begin
                            ctl.idx_clear = 1'b1;
                            state_next    = S_SCAN_ADDR;
                        end
                        else
                        begin
                            state_next = S_STATUS;
                        end
                    end
                    CMD_READ:
                    begin
                        if (!sts.count_zero)
                        begin
                            ctl.idx_clear = 1'b1;
                            state_next    = S_LIST_ADDR;
                        end
                        else
                        begin
                            state_next = S_STATUS;
                        end
                    end
                    default:
                    begin
                        state_next = S_STATUS;
                    end
                endcase
            end
            S_SCAN_ADDR:
            begin
                if (sts.idx_at_end)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    ctl.rd_scan = 1'b1;
                    state_next  = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                // on a hit, absorb the entry and fetch the tail to fill its slot
                if (sts.hit)
                begin
                    ctl.merge   = 1'b1;
                    ctl.rd_tail = 1'b1;
                    state_next  = S_MOVE;
                end
                else
                begin
                    ctl.idx_inc = 1'b1;
                    state_next  = S_SCAN_ADDR;
                end
            end
            S_MOVE:
            begin
                ctl.move_wr   = 1'b1;
                ctl.idx_clear = 1'b1;
                state_next    = S_SCAN_ADDR;
            end
            S_FINISH:
            begin
                if (sts.table_full)
                begin
                    ctl.overflow = 1'b1;
                end
                else
                begin
                    ctl.append = 1'b1;
                end
                state_next = S_STATUS;
            end
            S_STATUS:
            begin
                if (sts.out_free)
                begin
                    ctl.out_status = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LIST_ADDR:
            begin
                ctl.rd_scan = 1'b1;
                state_next  = S_LIST_LOAD;
            end
            S_LIST_LOAD:
            begin
                if (sts.out_free)
                begin
                    ctl.out_region = 1'b1;
                    if (sts.idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.idx_inc = 1'b1;
                        state_next  = S_LIST_ADDR;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/drm_datapath.sv
// drm_datapath: region table memory, working rectangle, compare and result register
// executes commands from drm_ctrl and reports status back
// depends on drm_pkg
module drm_datapath
    import drm_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  drm_cmd_item_t cmd_item,
    input  drm_ctl_t      ctl,
    output drm_sts_t      sts,
    output logic          res_valid,
    input  logic          res_stall,
    output drm_res_item_t res_item
);

    localparam int CW    = $clog2(MAX_REGIONS + 1);
    localparam int AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

    typedef struct packed {
        drm_coord_t left;
        drm_coord_t top;
        drm_coord_t right;
        drm_coord_t bottom;
    } rect_t;

    // region table
    rect_t mem [MAX_REGIONS];

    logic [1:0]    cmd_reg;
    logic          nonempty_reg;
    rect_t         rect_reg;
    rect_t         rect_next;
    rect_t         rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          repaint_reg;
    logic          repaint_next;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    logic [CW-1:0] idx_plus;
    logic [CW-1:0] tail;
    logic [AW-1:0] rd_addr;
    logic          res_valid_reg;
    drm_res_item_t res_reg;
    drm_res_item_t res_next;
    drm_coord_t    in_x;
    drm_coord_t    in_y;
    drm_coord_t    in_w;
    drm_coord_t    in_h;
    drm_coord_t    diff_w;
    drm_coord_t    diff_h;
    logic          hit;

    // sign-extended input rectangle
    assign in_x = {{(COORD_W-16){cmd_item.rect_x[15]}}, cmd_item.rect_x};
    assign in_y = {{(COORD_W-16){cmd_item.rect_y[15]}}, cmd_item.rect_y};
    assign in_w = {{(COORD_W-16){cmd_item.rect_width[15]}}, cmd_item.rect_width};
    assign in_h = {{(COORD_W-16){cmd_item.rect_height[15]}}, cmd_item.rect_height};

    assign idx_plus = idx_reg + CW'(1);
    assign tail     = count_reg - CW'(1);
    assign rd_addr  = ctl.rd_tail ? tail[AW-1:0] : idx_reg[AW-1:0];

    // touch or overlap test, edges inclusive
    assign hit = (rd_data_reg.left <= rect_reg.right) && (rect_reg.left <= rd_data_reg.right) &&
                 (rd_data_reg.top <= rect_reg.bottom) && (rect_reg.top <= rd_data_reg.bottom);

    // working rectangle next value
    always_comb
    begin
        rect_next = rect_reg;
        if (ctl.load_item)
        begin
            rect_next.left   = in_x;
            rect_next.top    = in_y;
            rect_next.right  = in_x + in_w;
            rect_next.bottom = in_y + in_h;
        end
        else if (ctl.merge)
        begin
            if (rd_data_reg.left < rect_reg.left)
            begin
                rect_next.left = rd_data_reg.left;
            end
            if (rd_data_reg.top < rect_reg.top)
            begin
                rect_next.top = rd_data_reg.top;
            end
            if (rd_data_reg.right > rect_reg.right)
            begin
                rect_next.right = rd_data_reg.right;
            end
            if (rd_data_reg.bottom > rect_reg.bottom)
            begin
                rect_next.bottom = rd_data_reg.bottom;
            end
        end
    end

    // table count, repaint flag and scan index next values
    always_comb
    begin
        count_next   = count_reg;
        repaint_next = repaint_reg;
        idx_next     = idx_reg;
        if (ctl.clear_table)
        begin
            count_next   = '0;
            repaint_next = 1'b0;
        end
        else if (ctl.merge)
        begin
            count_next = tail;
        end
        else if (ctl.append)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.overflow)
        begin
            count_next   = '0;
            repaint_next = 1'b1;
        end
        if (ctl.idx_clear)
        begin
            idx_next = '0;
        end
        else if (ctl.idx_inc)
        begin
            idx_next = idx_plus;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            repaint_reg   <= 1'b0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            repaint_reg <= repaint_next;
            idx_reg     <= idx_next;
            if (ctl.out_status || ctl.out_region)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // item and working registers
    always_ff @(posedge clk)
    begin
        rect_reg <= rect_next;
        if (ctl.load_item)
        begin
            cmd_reg      <= cmd_item.command;
            nonempty_reg <= !cmd_item.rect_width[15] && (cmd_item.rect_width != '0) &&
                            !cmd_item.rect_height[15] && (cmd_item.rect_height != '0);
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.move_wr)
        begin
            mem[idx_reg[AW-1:0]] <= rd_data_reg;
        end
        else if (ctl.append)
        begin
            mem[count_reg[AW-1:0]] <= rect_reg;
        end
        if (ctl.rd_scan || ctl.rd_tail)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign diff_w = rd_data_reg.right - rd_data_reg.left;
    assign diff_h = rd_data_reg.bottom - rd_data_reg.top;

    // result register next value
    always_comb
    begin
        res_next = res_reg;
        if (ctl.out_status)
        begin
            res_next               = '0;
            res_next.repaint_whole = repaint_reg;
            res_next.region_count  = COUNT_OUT_W'(count_reg);
            res_next.last          = 1'b1;
        end
        else if (ctl.out_region)
        begin
            res_next.region_x      = rd_data_reg.left[15:0];
            res_next.region_y      = rd_data_reg.top[15:0];
            res_next.region_width  = diff_w[16:0];
            res_next.region_height = diff_h[16:0];
            res_next.region_valid  = 1'b1;
            res_next.repaint_whole = repaint_reg;
            res_next.region_count  = COUNT_OUT_W'(count_reg);
            res_next.last          = (idx_plus == count_reg);
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_reg;

    // status to controller
    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.add_ok     = nonempty_reg && !repaint_reg;
        sts.count_zero = (count_reg == '0);
        sts.idx_at_end = (idx_reg >= count_reg);
        sts.idx_last   = (idx_plus == count_reg);
        sts.hit        = hit;
        sts.table_full = (count_reg >= CW'(MAX_REGIONS));
        sts.out_free   = !res_valid_reg || !res_stall;
    end

endmodule

>>> src/dirty_rectangle_merger.sv
// dirty_rectangle_merger: top level of the dirty rectangle merger
// instantiates drm_ctrl and drm_datapath; depends on drm_pkg
//
// Keeps a table of up to MAX_REGIONS dirty rectangles. One transaction is
// worked on at a time; the next one is taken in the cycle after its
// predecessor has placed its last result in the output register. A clear,
// an ignored add or an unused command goes from acceptance through dispatch
// to its status result. A read fetches and outputs each stored region in turn.
// An add scans the table, which has one read port: each entry is read and
// then compared; a merge moves the tail entry into the merged slot and the
// scan then restarts at entry 0; at the end the rectangle is appended, or the
// table overflows. A stalled result port holds the block in its output step
// while the stall lasts. Every command gives one status result, except a read of
// a non-empty table, which gives one result per region with last on the final one.
module dirty_rectangle_merger
    import drm_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  drm_cmd_item_t cmd_item,
    output logic          res_valid,
    input  logic          res_stall,
    output drm_res_item_t res_item
);

    drm_ctl_t ctl;
    drm_sts_t sts;

    // sequencing
    drm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    // table and result datapath
    drm_datapath #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_item  (cmd_item),
        .ctl       (ctl),
        .sts       (sts),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    // one transaction in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("new transaction taken while previous still in work");

    // a merge only happens against a non-empty table
    a_merge_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.merge |-> !sts.count_zero)
        else $error("merge issued on empty table");

    // append never goes past the table depth
    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.append |-> !sts.table_full)
        else $error("append into full table");

    // a status result is always the final result of its transaction
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_item.region_valid) |-> res_item.last)
        else $error("status result without last");

endmodule

>>> dv/drm_region_checker.sv
`timescale 1ns / 1ps
// drm_region_checker: watches both channels of the dirty rectangle merger, keeps its own
// copy of the region list, predicts every result transaction and compares them in order
// depends on drm_pkg
module drm_region_checker
    import drm_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_stall,
    input  drm_cmd_item_t cmd_item,
    input  logic          res_valid,
    input  logic          res_stall,
    input  drm_res_item_t res_item,
    output int            error_count,
    output int            outstanding
);

    // predicted region list, edges kept as left/top/right/bottom
    int            rgn_left   [MAX_REGIONS];
    int            rgn_top    [MAX_REGIONS];
    int            rgn_right  [MAX_REGIONS];
    int            rgn_bottom [MAX_REGIONS];
    int            rgn_total = 0;
    logic          repaint_flag = 1'b0;

    drm_res_item_t expected_reports[$];
    int            fail_tally = 0;
    int            queued = 0;

    assign error_count = fail_tally;
    assign outstanding = queued;

    // status-only result: no region, current flag and count
    function automatic drm_res_item_t status_report();
        drm_res_item_t rep;
        rep               = '0;
        rep.repaint_whole = repaint_flag;
        rep.region_count  = COUNT_OUT_W'(rgn_total);
        rep.last          = 1'b1;
        return rep;
    endfunction

    // one stored region as it comes out on a read
    function automatic drm_res_item_t region_report(int k, logic fin);
        drm_res_item_t rep;
        rep               = '0;
        rep.region_x      = 16'(rgn_left[k]);
        rep.region_y      = 16'(rgn_top[k]);
        rep.region_width  = 17'(rgn_right[k] - rgn_left[k]);
        rep.region_height = 17'(rgn_bottom[k] - rgn_top[k]);
        rep.region_valid  = 1'b1;
        rep.repaint_whole = repaint_flag;
        rep.region_count  = COUNT_OUT_W'(rgn_total);
        rep.last          = fin;
        return rep;
    endfunction

    // merge a rectangle into every touching region, restarting the scan after each merge
    task automatic absorb_rect(input int l, input int t, input int r, input int b);
        int i;
        int tail;
        i = 0;
        while (i < rgn_total)
        begin
            if (rgn_left[i] <= r && l <= rgn_right[i] &&
                rgn_top[i] <= b && t <= rgn_bottom[i])
            begin
                if (rgn_left[i] < l) l = rgn_left[i];
                if (rgn_top[i] < t) t = rgn_top[i];
                if (rgn_right[i] > r) r = rgn_right[i];
                if (rgn_bottom[i] > b) b = rgn_bottom[i];
                rgn_total--;
                tail          = rgn_total;
                rgn_left[i]   = rgn_left[tail];
                rgn_top[i]    = rgn_top[tail];
                rgn_right[i]  = rgn_right[tail];
                rgn_bottom[i] = rgn_bottom[tail];
                i = 0;
            end
            else
            begin
                i++;
            end
        end
        // still full after merging: give up and repaint everything
        if (rgn_total >= MAX_REGIONS)
        begin
            rgn_total    = 0;
            repaint_flag = 1'b1;
        end
        else
        begin
            rgn_left[rgn_total]   = l;
            rgn_top[rgn_total]    = t;
            rgn_right[rgn_total]  = r;
            rgn_bottom[rgn_total] = b;
            rgn_total++;
        end
    endtask

    // update the list for one accepted command and queue its results
    task automatic predict_command(input drm_cmd_item_t it);
        int   x;
        int   y;
        int   w;
        int   h;
        logic listed;
        x      = $signed(it.rect_x);
        y      = $signed(it.rect_y);
        w      = $signed(it.rect_width);
        h      = $signed(it.rect_height);
        listed = 1'b0;
        case (it.command)
            CMD_CLEAR:
            begin
                rgn_total    = 0;
                repaint_flag = 1'b0;
            end
            CMD_ADD:
            begin
                if (w > 0 && h > 0 && !repaint_flag)
                    absorb_rect(x, y, x + w, y + h);
            end
            CMD_READ:
            begin
                if (rgn_total > 0)
                begin
                    for (int k = 0; k < rgn_total; k++)
                        expected_reports.push_back(region_report(k, k == rgn_total - 1));
                    listed = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (!listed)
            expected_reports.push_back(status_report());
    endtask

    task automatic show_field(input string name, input logic signed [17:0] want_v,
                              input logic signed [17:0] got_v);
        if (want_v !== got_v)
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want_v, got_v);
    endtask

    // compare one result transaction with the oldest prediction
    task automatic check_report(input drm_res_item_t got);
        drm_res_item_t want;
        if (expected_reports.size() == 0)
        begin
            fail_tally++;
            $display("%0t ns: unexpected result, expected none, got %h", $time, got);
            return;
        end
        want = expected_reports.pop_front();
        if (got !== want)
        begin
            fail_tally++;
            show_field("region_x", want.region_x, got.region_x);
            show_field("region_y", want.region_y, got.region_y);
            show_field("region_width", want.region_width, got.region_width);
            show_field("region_height", want.region_height, got.region_height);
            show_field("region_valid", want.region_valid, got.region_valid);
            show_field("repaint_whole", want.repaint_whole, got.repaint_whole);
            show_field("region_count", want.region_count, got.region_count);
            show_field("last", want.last, got.last);
        end
    endtask

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgn_total    = 0;
            repaint_flag = 1'b0;
            expected_reports.delete();
            queued       = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_report(res_item);
            if (cmd_valid && !cmd_stall)
                predict_command(cmd_item);
            queued = expected_reports.size();
        end
    end

endmodule

>>> dv/dirty_rectangle_merger_test.sv
`timescale 1ns / 1ps
// dirty_rectangle_merger_test: stimulus and verdict for the dirty rectangle merger
// depends on drm_pkg, dirty_rectangle_merger and drm_region_checker
module dirty_rectangle_merger_test
    import drm_pkg::*;
;

    localparam int         DEPTH         = 16;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         RANDOM_CMDS   = 440;
    localparam int         SETTLE_CYCLES = 100;

    logic          clk;
    logic          rst_n;
    logic          cmd_valid;
    logic          cmd_stall;
    drm_cmd_item_t cmd_item;
    logic          res_valid;
    logic          res_stall;
    drm_res_item_t res_item;
    int            error_count;
    int            outstanding;
    int            cmds_sent;
    int            steady_left;

    dirty_rectangle_merger #(
        .MAX_REGIONS (DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    drm_region_checker #(
        .MAX_REGIONS (DEPTH)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd_item    (cmd_item),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_item    (res_item),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic drm_cmd_item_t make_cmd(logic [1:0] op, int x, int y, int w, int h);
        drm_cmd_item_t it;
        it.command     = op;
        it.rect_x      = 16'(x);
        it.rect_y      = 16'(y);
        it.rect_width  = 16'(w);
        it.rect_height = 16'(h);
        return it;
    endfunction

    // one command transaction, starting and ending at a falling edge
    task automatic issue(input drm_cmd_item_t it);
        int gap;
        if (steady_left > 0)
        begin
            steady_left--;
            gap = 0;
        end
        else
        begin
            if ($urandom_range(0, 24) == 0)
                steady_left = $urandom_range(8, 30);
            gap = pick_gap();
        end
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        @(negedge clk);
        cmds_sent++;
    endtask

    // hold off until every predicted result has come back
    task automatic drain_hold();
        cmd_valid <= 1'b0;
        @(negedge clk);
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    task automatic read_regions();
        issue(make_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom));
    endtask

    // rectangles packed into a small window so that they merge often
    task automatic run_cluster();
        int bx;
        int by;
        int x;
        int y;
        int w;
        int h;
        int pick;
        bx = int'($urandom_range(0, 65535 - 400)) - 32768;
        by = int'($urandom_range(0, 65535 - 400)) - 32768;
        if ($urandom_range(0, 3) == 0)
            issue(make_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
        repeat ($urandom_range(4, 20))
        begin
            pick = $urandom_range(0, 99);
            x    = bx + int'($urandom_range(0, 300));
            y    = by + int'($urandom_range(0, 300));
            w    = $urandom_range(1, 80);
            h    = $urandom_range(1, 80);
            if (pick < 8)
                w = -int'($urandom_range(0, 32768));
            else if (pick < 14)
                h = -int'($urandom_range(0, 32768));
            else if (pick < 26)
                w = $urandom_range(1, 32767);
            else if (pick < 32)
                h = $urandom_range(1, 32767);
            if ($urandom_range(0, 4) == 0)
                read_regions();
            issue(make_cmd(CMD_ADD, x, y, w, h));
        end
        read_regions();
    endtask

    // disjoint rectangles, sometimes enough that the list overflows into full repaint
    task automatic run_fill();
        int bx;
        int by;
        int fill_n;
        bx     = int'($urandom_range(0, 65535 - 2000)) - 32768;
        by     = int'($urandom_range(0, 65535 - 200)) - 32768;
        fill_n = $urandom_range(12, 19);
        issue(make_cmd(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
        for (int k = 0; k < fill_n; k++)
        begin
            issue(make_cmd(CMD_ADD, bx + k * 100 + int'($urandom_range(0, 30)),
                           by + int'($urandom_range(0, 100)),
                           $urandom_range(1, 60), $urandom_range(1, 60)));
            if ($urandom_range(0, 5) == 0)
                read_regions();
        end
        read_regions();
        // adds after an overflow are dropped while full repaint is up
        repeat ($urandom_range(1, 3))
            issue(make_cmd(CMD_ADD, bx, by, $urandom_range(1, 500), $urandom_range(1, 500)));
        read_regions();
    endtask

    // anything the fields allow
    task automatic run_noise();
        repeat ($urandom_range(3, 10))
            issue(make_cmd(2'($urandom), $urandom, $urandom, $urandom, $urandom));
    endtask

    // result side stall pattern
    initial
    begin
        int run;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
            repeat (run) @(negedge clk);
            res_stall <= 1'b1;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(8, 40) : $urandom_range(1, 3))
                @(negedge clk);
            res_stall <= 1'b0;
        end
    end

    // main stimulus
    initial
    begin
        int roll;
        int goal;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd_item    = '0;
        steady_left = 0;
        cmds_sent   = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty read, unused command, field extremes, empty rectangles
        read_regions();
        issue(make_cmd(CMD_UNUSED, -1, -1, -1, -1));
        issue(make_cmd(CMD_ADD, -32768, -32768, 32767, 32767));
        issue(make_cmd(CMD_ADD, 32767, 32767, 32767, 32767));
        issue(make_cmd(CMD_ADD, 5, 5, 0, 10));
        issue(make_cmd(CMD_ADD, 5, 5, -32768, 10));
        issue(make_cmd(CMD_ADD, 5, 5, 10, 0));
        issue(make_cmd(CMD_ADD, 5, 5, 10, -1));
        read_regions();
        issue(make_cmd(CMD_CLEAR, 0, 0, 0, 0));
        // edge touching: a bridge merges two regions, then a corner touch
        issue(make_cmd(CMD_ADD, 0, 0, 10, 10));
        issue(make_cmd(CMD_ADD, 20, 0, 5, 5));
        issue(make_cmd(CMD_ADD, 30, 30, 4, 4));
        issue(make_cmd(CMD_ADD, 10, 0, 10, 2));
        issue(make_cmd(CMD_ADD, 34, 34, 1, 1));
        read_regions();
        issue(make_cmd(CMD_CLEAR, -1, -1, -1, -1));
        read_regions();
        drain_hold();

        // random phases
        goal = cmds_sent + RANDOM_CMDS;
        while (cmds_sent < goal)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                run_cluster();
            else if (roll < 70)
                run_fill();
            else
                run_noise();
            if ($urandom_range(0, 29) == 0)
                drain_hold();
        end
        cmd_valid <= 1'b0;

        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #30_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
